// File: rtl/fte_pkg.sv
// shared types and constants for the ip five-tuple extractor
`default_nettype none

package fte_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_ipv6;
        logic [7:0]  protocol;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [63:0] destination_high;
        logic [63:0] destination_low;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2
    } t_kind;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_NOT_IP  = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    localparam logic [3:0] VER_IPV4   = 4'd4;
    localparam logic [3:0] VER_IPV6   = 4'd6;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [5:0] IPV6_HLEN  = 6'd40;

    localparam int OFF_W = 7;

endpackage

`default_nettype wire

// File: rtl/ip_five_tuple_extractor_core.sv
// top level of the ip five-tuple extractor
// usage:
//   input channel carries one packet byte per request with a last-byte mark,
//   starting at the first byte of the ip header. output channel carries one
//   five-tuple request per packet: status, version flag, protocol, 128-bit
//   source and destination addresses and tcp/udp ports.
//   a request is taken at a clock edge where valid is high and stall is low.
// timing:
//   one byte per cycle sustained unless a held result stalls. a byte in the input
//   register is parsed by the offset compare and field capture between the input
//   and result registers; any result it yields is loaded into the result register.
//   the result comes out at the byte that completes the addresses and, for tcp/udp, the ports,
//   at the first byte for a non-ip version, or at the last byte if the
//   packet ends early. bytes after the result are dropped up to the mark.
// reset:
//   synchronous active-low reset empties both registers and clears all
//   parse state; the next byte is treated as the start of a packet.
// backpressure:
//   a stalled result holds; the input register keeps filling, then the
//   input stalls once a byte is waiting behind the held result.
`default_nettype none

module ip_five_tuple_extractor_core
    import fte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic      in_valid;
    t_in_item  in_item;
    logic      out_ready;
    logic      step;
    logic      emit;
    t_out_item result;

    assign step = in_valid && out_ready;

    fte_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_valid    (in_valid),
        .o_item     (in_item),
        .i_take     (out_ready)
    );

    fte_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (in_item),
        .o_emit   (emit),
        .o_result (result)
    );

    fte_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step && emit),
        .i_item      (result),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // non-parsed results carry nothing but the status
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_PARSED |->
            o_out_data.is_ipv6 == 1'b0 && o_out_data.protocol == '0 &&
            o_out_data.source_high == '0 && o_out_data.source_low == '0 &&
            o_out_data.destination_high == '0 && o_out_data.destination_low == '0 &&
            o_out_data.source_port == '0 && o_out_data.destination_port == '0)
        else $error("non-parsed result with nonzero fields");

    // ipv4 addresses live in the low 32 bits only
    a_v4_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_PARSED && !o_out_data.is_ipv6 |->
            o_out_data.source_high == '0 && o_out_data.destination_high == '0 &&
            o_out_data.source_low[63:32] == '0 &&
            o_out_data.destination_low[63:32] == '0)
        else $error("ipv4 result with upper address bits set");

    // the input only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("registers not empty after reset");

endmodule

`default_nettype wire

// File: rtl/fte_in_reg.sv
// input register that holds one request until the parser takes it
`default_nettype none

module fte_in_reg
    import fte_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_valid,
    output t_in_item      o_item,
    input  wire logic     i_take
);

    logic     r_valid;
    t_in_item r_item;

    assign o_in_stall = r_valid && !i_take;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fte_parser.sv
// per-packet parse state and the byte-at-a-time field capture
`default_nettype none

module fte_parser
    import fte_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output logic          o_emit,
    output t_out_item     o_result
);

    logic [OFF_W-1:0] r_offset, n_offset;
    t_kind            r_kind, n_kind;
    logic [5:0]       r_hlen, n_hlen;
    logic [7:0]       r_proto, n_proto;
    logic [63:0]      r_src_hi, n_src_hi;
    logic [63:0]      r_src_lo, n_src_lo;
    logic [63:0]      r_dst_hi, n_dst_hi;
    logic [63:0]      r_dst_lo, n_dst_lo;
    logic [31:0]      r_ports, n_ports;
    logic             r_sent, n_sent;

    always_comb begin
        logic [7:0]       b;
        logic [OFF_W-1:0] o;
        logic [OFF_W-1:0] hl;
        logic             tp;
        logic             done;

        b        = i_item.data_byte;
        o        = r_offset;
        n_offset = r_offset;
        n_kind   = r_kind;
        n_hlen   = r_hlen;
        n_proto  = r_proto;
        n_src_hi = r_src_hi;
        n_src_lo = r_src_lo;
        n_dst_hi = r_dst_hi;
        n_dst_lo = r_dst_lo;
        n_ports  = r_ports;
        n_sent   = r_sent;
        o_emit   = 1'b0;
        o_result = '0;
        hl       = '0;
        tp       = 1'b0;
        done     = 1'b0;

        if (!r_sent) begin
            if (o == '0) begin
                priority if (b[7:4] == VER_IPV4) begin
                    n_kind = KIND_V4;
                    n_hlen = {b[3:0], 2'b00};
                end else if (b[7:4] == VER_IPV6) begin
                    n_kind = KIND_V6;
                    n_hlen = IPV6_HLEN;
                end else begin
                    n_kind          = KIND_NONE;
                    n_sent          = 1'b1;
                    o_emit          = 1'b1;
                    o_result.status = ST_NOT_IP;
                end
            end

            if (!n_sent) begin
                if (n_kind == KIND_V4) begin
                    if (o == 7'd9) begin
                        n_proto = b;
                    end else if (o >= 7'd12 && o <= 7'd15) begin
                        n_src_lo = {r_src_lo[55:0], b};
                    end else if (o >= 7'd16 && o <= 7'd19) begin
                        n_dst_lo = {r_dst_lo[55:0], b};
                    end
                end else begin
                    if (o == 7'd6) begin
                        n_proto = b;
                    end else if (o >= 7'd8 && o <= 7'd15) begin
                        n_src_hi = {r_src_hi[55:0], b};
                    end else if (o >= 7'd16 && o <= 7'd23) begin
                        n_src_lo = {r_src_lo[55:0], b};
                    end else if (o >= 7'd24 && o <= 7'd31) begin
                        n_dst_hi = {r_dst_hi[55:0], b};
                    end else if (o >= 7'd32 && o <= 7'd39) begin
                        n_dst_lo = {r_dst_lo[55:0], b};
                    end
                end

                // ports are the four bytes right after the header
                hl = {1'b0, n_hlen};
                if (o >= hl && o < hl + 7'd4) begin
                    n_ports = {r_ports[23:0], b};
                end

                tp = (n_proto == PROTO_TCP) || (n_proto == PROTO_UDP);
                if (n_kind == KIND_V4) begin
                    done = (o >= 7'd19) && (!tp || o >= hl + 7'd3);
                end else begin
                    done = (o >= 7'd39) && (!tp || o >= 7'd43);
                end

                priority if (done) begin
                    n_sent                    = 1'b1;
                    o_emit                    = 1'b1;
                    o_result.status           = ST_PARSED;
                    o_result.is_ipv6          = (n_kind == KIND_V6);
                    o_result.protocol         = n_proto;
                    o_result.source_high      = n_src_hi;
                    o_result.source_low       = n_src_lo;
                    o_result.destination_high = n_dst_hi;
                    o_result.destination_low  = n_dst_lo;
                    if (tp) begin
                        o_result.source_port      = n_ports[31:16];
                        o_result.destination_port = n_ports[15:0];
                    end
                end else if (i_item.last_byte) begin
                    n_sent          = 1'b1;
                    o_emit          = 1'b1;
                    o_result.status = ST_TRUNC;
                end else begin
                    n_offset = o + 7'd1;
                end
            end
        end

        // the last byte always starts the next packet from scratch
        if (i_item.last_byte) begin
            n_offset = '0;
            n_kind   = KIND_NONE;
            n_hlen   = '0;
            n_proto  = '0;
            n_src_hi = '0;
            n_src_lo = '0;
            n_dst_hi = '0;
            n_dst_lo = '0;
            n_ports  = '0;
            n_sent   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_kind   <= KIND_NONE;
            r_hlen   <= '0;
            r_proto  <= '0;
            r_src_hi <= '0;
            r_src_lo <= '0;
            r_dst_hi <= '0;
            r_dst_lo <= '0;
            r_ports  <= '0;
            r_sent   <= 1'b0;
        end else if (i_step) begin
            r_offset <= n_offset;
            r_kind   <= n_kind;
            r_hlen   <= n_hlen;
            r_proto  <= n_proto;
            r_src_hi <= n_src_hi;
            r_src_lo <= n_src_lo;
            r_dst_hi <= n_dst_hi;
            r_dst_lo <= n_dst_lo;
            r_ports  <= n_ports;
            r_sent   <= n_sent;
        end
    end

endmodule

`default_nettype wire

// File: rtl/fte_out_reg.sv
// result register toward the downstream channel
`default_nettype none

module fte_out_reg
    import fte_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_out_item i_item,
    output logic           o_ready,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    logic      r_valid;
    t_out_item r_item;

    // slot frees up in the same cycle the current request is taken
    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire
